>>> src/gdcf_pkg.sv
// ============================================================================
// gdcf_pkg: shared constants, tables and types of the calendar field pipeline
// Holds the reciprocal constants for the constant divisions, the month tables
// and the structures that carry a date from one pipeline segment to the next.
// ============================================================================
package gdcf_pkg;

    // Epochs and the shift that makes every year of the pipeline non-negative.
    localparam int JDN_UNIX_EPOCH = 2440588;
    localparam int MJD_UNIX_EPOCH = 40587;
    localparam int ERA_SHIFT_DAYS = 719468;
    localparam int YEAR_BIAS_I    = 32800;     // 82 whole 400-year eras
    localparam int MOD7_BIAS_I    = 10500000;  // multiple of 7, keeps JDN positive

    localparam int DAY_BIAS_I = JDN_UNIX_EPOCH - ERA_SHIFT_DAYS - YEAR_BIAS_I * 365
                              - YEAR_BIAS_I / 4 + YEAR_BIAS_I / 100 - YEAR_BIAS_I / 400;

    localparam logic [15:0] YEAR_BAD   = 16'h8000;
    localparam logic [16:0] YEAR_BIAS  = 17'(YEAR_BIAS_I);
    localparam logic [25:0] DAY_BIAS   = 26'(DAY_BIAS_I);
    localparam logic [24:0] JV_BIAS    = 25'(DAY_BIAS_I + MOD7_BIAS_I);
    localparam logic [24:0] MJD_OFFSET = 25'(JDN_UNIX_EPOCH - MJD_UNIX_EPOCH);
    localparam logic [24:0] DAYS_YEAR  = 25'd365;

    // Division by 100 of a 17-bit value: exact for the whole range.
    localparam logic [17:0] RECIP_100    = 18'd167773;
    localparam int          RECIP_100_SH = 24;
    localparam logic [6:0]  CENTURY      = 7'd100;

    // Division by 7 of a 25-bit value: exact below 2**25.
    localparam logic [25:0] RECIP_7    = 26'd38347923;
    localparam int          RECIP_7_SH = 28;

    // Division by 7 of values below 682.
    localparam logic [9:0] RECIP_7_SMALL    = 10'd586;
    localparam int         RECIP_7_SMALL_SH = 12;

    localparam logic [7:0] MONTH_JAN = 8'd1;
    localparam logic [7:0] MONTH_FEB = 8'd2;
    localparam logic [7:0] MONTH_DEC = 8'd12;
    localparam logic [7:0] DAY_MAX   = 8'd31;
    localparam logic [4:0] FEB_LEAP  = 5'd29;

    localparam logic [2:0] LEAD_THU   = 3'd6;
    localparam logic [2:0] LEAD_WED   = 3'd5;
    localparam logic [7:0] WEEK_LONG  = 8'd53;
    localparam logic [7:0] WEEK_FIRST = 8'd1;

    // Days in each month of a common year.
    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] r;
        case (m)
            4'd1:    r = 5'd31;
            4'd2:    r = 5'd28;
            4'd3:    r = 5'd31;
            4'd4:    r = 5'd30;
            4'd5:    r = 5'd31;
            4'd6:    r = 5'd30;
            4'd7:    r = 5'd31;
            4'd8:    r = 5'd31;
            4'd9:    r = 5'd30;
            4'd10:   r = 5'd31;
            4'd11:   r = 5'd30;
            4'd12:   r = 5'd31;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // Days from 1 March to the first of the month, with the year starting in March.
    function automatic logic [8:0] month_march_ofs(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd3:    r = 9'd0;
            4'd4:    r = 9'd31;
            4'd5:    r = 9'd61;
            4'd6:    r = 9'd92;
            4'd7:    r = 9'd122;
            4'd8:    r = 9'd153;
            4'd9:    r = 9'd184;
            4'd10:   r = 9'd214;
            4'd11:   r = 9'd245;
            4'd12:   r = 9'd275;
            4'd1:    r = 9'd306;
            4'd2:    r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Days before the first of the month in a common year.
    function automatic logic [8:0] month_cum(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // A checked date, ready for the day count.
    typedef struct packed {
        logic        ok;
        logic        bad_year;
        logic        bad_month;
        logic        bad_day;
        logic [4:0]  mlen;
        logic        leap_cur;
        logic        leap_prev;
        logic [16:0] ybase;      // biased year, one less for January and February
        logic [9:0]  cent;       // ybase / 100
        logic [9:0]  march_day;  // day within the March-based year
        logic [8:0]  ydoy;       // ordinal day
    } gdcf_date_t;

    // A counted date, ready for the weekday and week number.
    typedef struct packed {
        logic               ok;
        logic               bad_year;
        logic               bad_month;
        logic               bad_day;
        logic [4:0]         mlen;
        logic               leap_cur;
        logic               leap_prev;
        logic [8:0]         ydoy;
        logic [2:0]         ydoy_m7;
        logic signed [24:0] jdn;
        logic signed [24:0] mjd;
        logic [2:0]         jv_lo;
        logic [2:0]         q7_lo;
    } gdcf_day_t;

endpackage

>>> src/gregorian_date_calendar_fields.sv
// ============================================================================
// gregorian_date_calendar_fields: proleptic Gregorian date to calendar fields
// Checks a year, month and day and returns the Julian day number, modified
// Julian day, ISO weekday, ordinal day, month length and ISO week number.
// ============================================================================
// The block takes one date per clock cycle while in_stall is low and returns
// its result beats in the same order as the inputs. The work is spread over
// an eight-stage pipeline: three stages check the fields
// and split the year by centuries, three build the Julian day number and its
// residue modulo 7, and two derive the weekday and week number and hold the
// result register. Every stage carries its own valid bit and moves forward
// whenever it is empty or the stage after it moves, so a held result beat
// stalls only the stages that are full behind it; input beats keep being taken
// as long as some stage in the pipe is empty. A beat with date_ok low carries
// its three error flags and zeros in every other field. When the month is
// invalid, bad_day reports only a day outside 1 to 31. The week number gives
// week 53 only when 1 January is a Thursday, or a Wednesday in a leap year;
// week 0 becomes the last week of the previous year.
// ============================================================================
module gregorian_date_calendar_fields
    import gdcf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] year_in,
    input  logic [7:0]         month_in,
    input  logic [7:0]         day_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               date_ok,
    output logic               bad_year,
    output logic               bad_month,
    output logic               bad_day,
    output logic signed [24:0] julian_day_number,
    output logic signed [24:0] modified_julian_day,
    output logic [2:0]         iso_weekday,
    output logic [8:0]         day_in_year,
    output logic [5:0]         iso_week,
    output logic [4:0]         month_length
);

    // Segment boundaries: valid forward, stall backward, payload as a struct.
    logic       chk_valid, chk_stall;
    logic       cnt_valid, cnt_stall;
    gdcf_date_t chk_date;
    gdcf_day_t  cnt_day;

    // Field checks, leap years and the year split by centuries.
    gdcf_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .year_in   (year_in),
        .month_in  (month_in),
        .day_in    (day_in),
        .out_valid (chk_valid),
        .out_stall (chk_stall),
        .date_out  (chk_date)
    );

    // Julian day number, modified Julian day and the weekday residue.
    gdcf_daycount u_daycount (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chk_valid),
        .in_stall  (chk_stall),
        .date_in   (chk_date),
        .out_valid (cnt_valid),
        .out_stall (cnt_stall),
        .day_out   (cnt_day)
    );

    // Weekday, week number and the result register.
    gdcf_week u_week (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (cnt_valid),
        .in_stall            (cnt_stall),
        .day_in              (cnt_day),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .date_ok             (date_ok),
        .bad_year            (bad_year),
        .bad_month           (bad_month),
        .bad_day             (bad_day),
        .julian_day_number   (julian_day_number),
        .modified_julian_day (modified_julian_day),
        .iso_weekday         (iso_weekday),
        .day_in_year         (day_in_year),
        .iso_week            (iso_week),
        .month_length        (month_length)
    );

    // The input side can only be held back when the whole pipe is full
    // behind a stalled result beat.
    a_stall_needs_full_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the result register is free");

    // The verdict agrees with the three error flags.
    a_ok_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (date_ok == !(bad_year || bad_month || bad_day)))
        else $error("date_ok disagrees with the error flags");

    // An invalid date carries zeros in every computed field.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !date_ok) |-> ((julian_day_number == 25'sd0)
            && (modified_julian_day == 25'sd0) && (iso_weekday == 3'd0)
            && (day_in_year == 9'd0) && (iso_week == 6'd0) && (month_length == 5'd0)))
        else $error("invalid date with a nonzero field");

    // The two day counts of a valid date differ by the fixed epoch offset.
    a_mjd_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && date_ok) |->
            (25'(julian_day_number - modified_julian_day) == MJD_OFFSET))
        else $error("modified Julian day out of step with Julian day number");

    // A valid date has a weekday, a week and an ordinal day in range.
    a_valid_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && date_ok) |-> ((iso_weekday != 3'd0) && (iso_week != 6'd0)
            && (iso_week <= 6'd53) && (day_in_year != 9'd0) && (month_length >= 5'd28)))
        else $error("valid date with a field out of range");

endmodule

>>> src/gdcf_check.sv
// ============================================================================
// gdcf_check: field checks, leap years and year split
// Three stages: year bias, division by 100, then validity, month length and
// the day offsets used by the day count.
// ============================================================================
module gdcf_check
    import gdcf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] year_in,
    input  logic [7:0]         month_in,
    input  logic [7:0]         day_in,
    output logic               out_valid,
    input  logic               out_stall,
    output gdcf_date_t         date_out
);

    logic        v1_reg, v2_reg, v3_reg;
    logic        en1, en2, en3;
    logic [16:0] bias1_reg, bias2_reg;
    logic [7:0]  month1_reg, month2_reg, day1_reg, day2_reg;
    logic        bady1_reg, bady2_reg, badm1_reg, badm2_reg;
    logic [9:0]  cent2_reg;
    logic [9:0]  cent_next;
    logic [34:0] prod100;
    gdcf_date_t  date_reg, date_next;

    logic [16:0] rem_full, bias_prev;
    logic [6:0]  rem0;
    logic        rem_zero, rem_one;
    logic [9:0]  cent_prev;
    logic        leap_cur, leap_prev, late;
    logic [4:0]  mlen;
    logic        bad_day;
    logic [3:0]  mon;

    assign en3      = !v3_reg || !out_stall;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    assign out_valid = v3_reg;
    assign date_out  = date_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage two: quotient by 100 through a reciprocal multiply.
    assign prod100   = 35'(bias1_reg) * 35'(RECIP_100);
    assign cent_next = prod100[RECIP_100_SH +: 10];

    // Stage three: remainder, leap years of this and the previous year.
    assign rem_full  = bias2_reg - 17'(cent2_reg) * 17'(CENTURY);
    assign rem0      = rem_full[6:0];
    assign rem_zero  = (rem0 == 7'd0);
    assign rem_one   = (rem0 == 7'd1);
    assign bias_prev = bias2_reg - 17'd1;
    assign cent_prev = rem_zero ? (cent2_reg - 10'd1) : cent2_reg;
    assign leap_cur  = (bias2_reg[1:0] == 2'd0) && (!rem_zero || (cent2_reg[1:0] == 2'd0));
    assign leap_prev = (bias_prev[1:0] == 2'd0) && (!rem_one || (cent_prev[1:0] == 2'd0));

    assign mon  = month2_reg[3:0];
    assign late = (month2_reg > MONTH_FEB);
    assign mlen = ((month2_reg == MONTH_FEB) && leap_cur) ? FEB_LEAP : month_days(mon);

    always_comb
    begin
        if (badm2_reg)
        begin
            bad_day = (day2_reg == 8'd0) || (day2_reg > DAY_MAX);
        end
        else
        begin
            bad_day = (day2_reg == 8'd0) || (day2_reg > {3'b000, mlen});
        end
    end

    always_comb
    begin
        date_next.ok        = !bady2_reg && !badm2_reg && !bad_day;
        date_next.bad_year  = bady2_reg;
        date_next.bad_month = badm2_reg;
        date_next.bad_day   = bad_day;
        date_next.mlen      = mlen;
        date_next.leap_cur  = leap_cur;
        date_next.leap_prev = leap_prev;
        date_next.ybase     = late ? bias2_reg : bias_prev;
        date_next.cent      = late ? cent2_reg : cent_prev;
        date_next.march_day = 10'(month_march_ofs(mon)) + 10'(day2_reg) - 10'd1;
        date_next.ydoy      = month_cum(mon) + 9'(day2_reg) + 9'(late && leap_cur);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            bias1_reg  <= {year_in[15], year_in} + YEAR_BIAS;
            month1_reg <= month_in;
            day1_reg   <= day_in;
            bady1_reg  <= ({year_in} == YEAR_BAD);
            badm1_reg  <= (month_in < MONTH_JAN) || (month_in > MONTH_DEC);
        end
        if (en2)
        begin
            bias2_reg  <= bias1_reg;
            cent2_reg  <= cent_next;
            month2_reg <= month1_reg;
            day2_reg   <= day1_reg;
            bady2_reg  <= bady1_reg;
            badm2_reg  <= badm1_reg;
        end
        if (en3)
        begin
            date_reg <= date_next;
        end
    end

endmodule

>>> src/gdcf_daycount.sv
// ============================================================================
// gdcf_daycount: Julian day number and its residue modulo 7
// Three stages: year terms, the final sum, then the reciprocal multiply by
// which the weekday residue is found.
// ============================================================================
module gdcf_daycount
    import gdcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  gdcf_date_t date_in,
    output logic       out_valid,
    input  logic       out_stall,
    output gdcf_day_t  day_out
);

    logic        v1_reg, v2_reg, v3_reg;
    logic        en1, en2, en3;
    gdcf_date_t  date1_reg, date2_reg;
    logic [24:0] prod1_reg, prod_next;
    logic [25:0] sum1_reg, sum_next, part;
    logic [24:0] base1_reg, base_next;
    logic [24:0] jdn2_reg, jdn_next;
    logic [24:0] jv2_reg, jv_next;
    logic [50:0] q7_prod;
    logic [18:0] yq_prod;
    logic [6:0]  yq;
    logic [8:0]  ym_full;
    gdcf_day_t   day_reg, day_next;

    assign en3      = !v3_reg || !out_stall;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    assign out_valid = v3_reg;
    assign day_out   = day_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage one: 365 days a year plus the leap-day corrections and day offset.
    assign prod_next = 25'(date_in.ybase) * DAYS_YEAR;
    assign part      = 26'(date_in.ybase >> 2) - 26'(date_in.cent)
                     + 26'(date_in.cent >> 2) + 26'(date_in.march_day);
    assign sum_next  = part + DAY_BIAS;
    assign base_next = part[24:0] + JV_BIAS;

    // Stage two: signed day number and the same number shifted positive.
    assign jdn_next = 25'(26'(prod1_reg) + sum1_reg);
    assign jv_next  = prod1_reg + base1_reg;

    // Stage three: low bits of the quotient by 7, and the ordinal day modulo 7.
    assign q7_prod = 51'(jv2_reg) * 51'(RECIP_7);
    assign yq_prod = 19'(date2_reg.ydoy) * 19'(RECIP_7_SMALL);
    assign yq      = yq_prod[RECIP_7_SMALL_SH +: 7];
    assign ym_full = date2_reg.ydoy - 9'(yq) * 9'd7;

    always_comb
    begin
        day_next.ok        = date2_reg.ok;
        day_next.bad_year  = date2_reg.bad_year;
        day_next.bad_month = date2_reg.bad_month;
        day_next.bad_day   = date2_reg.bad_day;
        day_next.mlen      = date2_reg.mlen;
        day_next.leap_cur  = date2_reg.leap_cur;
        day_next.leap_prev = date2_reg.leap_prev;
        day_next.ydoy      = date2_reg.ydoy;
        day_next.ydoy_m7   = ym_full[2:0];
        day_next.jdn       = $signed(jdn2_reg);
        day_next.mjd       = $signed(jdn2_reg - MJD_OFFSET);
        day_next.jv_lo     = jv2_reg[2:0];
        day_next.q7_lo     = q7_prod[RECIP_7_SH +: 3];
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            date1_reg <= date_in;
            prod1_reg <= prod_next;
            sum1_reg  <= sum_next;
            base1_reg <= base_next;
        end
        if (en2)
        begin
            date2_reg <= date1_reg;
            jdn2_reg  <= jdn_next;
            jv2_reg   <= jv_next;
        end
        if (en3)
        begin
            day_reg <= day_next;
        end
    end

endmodule

>>> src/gdcf_week.sv
// ============================================================================
// gdcf_week: weekday, ISO week number and the output register
// Stage one finds the weekday and the weekday of 1 January; stage two divides
// by 7, applies the long-year rule and zeroes the fields of an invalid date.
// ============================================================================
module gdcf_week
    import gdcf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  gdcf_day_t          day_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               date_ok,
    output logic               bad_year,
    output logic               bad_month,
    output logic               bad_day,
    output logic signed [24:0] julian_day_number,
    output logic signed [24:0] modified_julian_day,
    output logic [2:0]         iso_weekday,
    output logic [8:0]         day_in_year,
    output logic [5:0]         iso_week,
    output logic [4:0]         month_length
);

    logic        v1_reg, v2_reg;
    logic        en1, en2;
    gdcf_day_t   day1_reg;
    logic [2:0]  wd1_reg, wd_next;
    logic [9:0]  xcur1_reg, xcur_next, xprev1_reg, xprev_next;
    logic        long1_reg, long_next;

    logic [2:0]  wd_idx;
    logic [4:0]  lead_sum;
    logic [2:0]  lead;
    logic [3:0]  prev_sum;
    logic [2:0]  lead_prev;

    logic [19:0] wkc_prod, wkp_prod;
    logic [7:0]  wk_cur, wk_prev, wk_sel, wk_fix;

    logic               ok_reg, bady_reg, badm_reg, badd_reg;
    logic signed [24:0] jdn_reg, mjd_reg;
    logic [2:0]         wday_reg;
    logic [8:0]         ydoy_reg;
    logic [5:0]         week_reg;
    logic [4:0]         mlen_reg;

    assign en2      = !v2_reg || !out_stall;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Stage one: weekday residue, then the lead of 1 January of this and the
    // previous year, both brought back into 0..6.
    assign wd_idx   = day_in.jv_lo - day_in.q7_lo * 3'd7;
    assign wd_next  = wd_idx + 3'd1;
    assign lead_sum = {2'b00, wd_idx} + 5'd11 - {2'b00, day_in.ydoy_m7};

    always_comb
    begin
        if (lead_sum >= 5'd14)
        begin
            lead = 3'(lead_sum - 5'd14);
        end
        else if (lead_sum >= 5'd7)
        begin
            lead = 3'(lead_sum - 5'd7);
        end
        else
        begin
            lead = lead_sum[2:0];
        end
    end

    assign prev_sum  = {1'b0, lead} + 4'd6 - 4'(day_in.leap_prev);
    assign lead_prev = (prev_sum >= 4'd7) ? 3'(prev_sum - 4'd7) : prev_sum[2:0];

    assign xcur_next  = 10'(day_in.ydoy) + 10'(lead) + 10'd3;
    assign xprev_next = 10'(day_in.ydoy) + 10'd368 + 10'(day_in.leap_prev) + 10'(lead_prev);
    assign long_next  = (lead == LEAD_THU) || ((lead == LEAD_WED) && day_in.leap_cur);

    // Stage two: week numbers by reciprocal, then the long-year and week-zero rules.
    assign wkc_prod = 20'(xcur1_reg) * 20'(RECIP_7_SMALL);
    assign wkp_prod = 20'(xprev1_reg) * 20'(RECIP_7_SMALL);
    assign wk_cur   = wkc_prod[RECIP_7_SMALL_SH +: 8];
    assign wk_prev  = wkp_prod[RECIP_7_SMALL_SH +: 8];

    always_comb
    begin
        if (wk_cur == WEEK_LONG)
        begin
            wk_sel = long1_reg ? WEEK_LONG : WEEK_FIRST;
        end
        else if (wk_cur == 8'd0)
        begin
            wk_sel = wk_prev;
        end
        else
        begin
            wk_sel = wk_cur;
        end
        wk_fix = (wk_sel > WEEK_LONG) ? WEEK_LONG : wk_sel;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            day1_reg   <= day_in;
            wd1_reg    <= wd_next;
            xcur1_reg  <= xcur_next;
            xprev1_reg <= xprev_next;
            long1_reg  <= long_next;
        end
        if (en2)
        begin
            ok_reg   <= day1_reg.ok;
            bady_reg <= day1_reg.bad_year;
            badm_reg <= day1_reg.bad_month;
            badd_reg <= day1_reg.bad_day;
            jdn_reg  <= day1_reg.ok ? day1_reg.jdn : 25'sd0;
            mjd_reg  <= day1_reg.ok ? day1_reg.mjd : 25'sd0;
            wday_reg <= day1_reg.ok ? wd1_reg : 3'd0;
            ydoy_reg <= day1_reg.ok ? day1_reg.ydoy : 9'd0;
            week_reg <= day1_reg.ok ? wk_fix[5:0] : 6'd0;
            mlen_reg <= day1_reg.ok ? day1_reg.mlen : 5'd0;
        end
    end

    assign out_valid           = v2_reg;
    assign date_ok             = ok_reg;
    assign bad_year            = bady_reg;
    assign bad_month           = badm_reg;
    assign bad_day             = badd_reg;
    assign julian_day_number   = jdn_reg;
    assign modified_julian_day = mjd_reg;
    assign iso_weekday         = wday_reg;
    assign day_in_year         = ydoy_reg;
    assign iso_week            = week_reg;
    assign month_length        = mlen_reg;

endmodule
